[sv/clst_pkg.sv]
// clst_pkg: widths, codes and cell command type for the circular list store.
// Used by clst_cell and circular_list_store. No dependencies.
package clst_pkg;

    localparam int CAPACITY = 16;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int POS_W  = 5;
    localparam int EIDX_W = 4;
    localparam int STS_W  = 2;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [CNT_W-1:0] count;
        logic [CMP_W-1:0] pos;
    } cell_cmd_t;

endpackage

[sv/clst_cell.sv]
// clst_cell: one list slot; loads a new value or takes a neighbor's or the head cell's value.
// Depends on clst_pkg.
module clst_cell (
    input  logic                         aclk,
    input  clst_pkg::cell_cmd_t          cmd,
    input  logic [clst_pkg::IDX_W-1:0]   idx,
    input  logic [clst_pkg::DATA_W-1:0]  value,
    input  logic [clst_pkg::DATA_W-1:0]  left_data,
    input  logic [clst_pkg::DATA_W-1:0]  right_data,
    input  logic [clst_pkg::DATA_W-1:0]  head_data,
    output logic [clst_pkg::DATA_W-1:0]  data
);
    import clst_pkg::*;

    logic [DATA_W-1:0] data_reg, data_next;
    logic [CMP_W-1:0]  slot_pos;
    logic [CMP_W-1:0]  cnt;

    always_comb begin
        slot_pos  = CMP_W'(idx) + CMP_W'(1);
        cnt       = CMP_W'(cmd.count);
        data_next = data_reg;
        case (cmd.op)
            CELL_APPEND: begin
                if (CMP_W'(idx) == cnt) begin
                    data_next = value;
                end
            end
            CELL_INSERT: begin
                data_next = (idx == '0) ? value : left_data;
            end
            CELL_DELETE: begin
                if (slot_pos >= cmd.pos) begin
                    data_next = right_data;
                end
            end
            CELL_ROTATE: begin
                if (slot_pos < cnt) begin
                    data_next = right_data;
                end else if (slot_pos == cnt) begin
                    data_next = head_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[sv/circular_list_store.sv]
// circular_list_store: bounded ordered list in a chain of shifting cells.
// Depends on clst_pkg and clst_cell.
//
//  channel | ports                                            | direction
//  s_      | s_valid s_ready s_operation s_value s_position   | in
//  m_      | m_valid m_ready m_element m_element_index m_last m_status | out
//
// Edits are registered: all cells update at once; a new item is taken each cycle
// while the output register is free or being drained.
// A read-out runs in the stream state: the cells rotate by one per result and are
// back in place after the last; no item is taken meanwhile.
// Reset (aresetn low, synchronous) empties the list; cell contents are not cleared.
// A stalled m_ready holds the result register and blocks new items and streaming.
module circular_list_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [clst_pkg::OP_W-1:0]     s_operation,
    input  logic signed [clst_pkg::DATA_W-1:0] s_value,
    input  logic [clst_pkg::POS_W-1:0]    s_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [clst_pkg::DATA_W-1:0] m_element,
    output logic [clst_pkg::EIDX_W-1:0]   m_element_index,
    output logic                          m_last,
    output logic [clst_pkg::STS_W-1:0]    m_status
);
    import clst_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_element_reg, m_element_next;
    logic [EIDX_W-1:0] m_index_reg, m_index_next;
    logic              m_last_reg, m_last_next;
    status_t           m_status_reg, m_status_next;

    logic              out_free;
    logic              accept;
    logic              full;
    logic              empty;
    logic              rd_last;
    logic [CMP_W-1:0]  pos_ext;
    op_t               op;
    cell_cmd_t         cmd;

    logic [DATA_W-1:0] cell_data [CAPACITY];

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign op       = op_t'(s_operation);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign pos_ext  = CMP_W'(s_position);
    assign rd_last  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmd.op         = CELL_HOLD;
        cmd.count      = count_reg;
        cmd.pos        = pos_ext;
        m_valid_next   = m_valid_reg && !m_ready;
        m_element_next = m_element_reg;
        m_index_next   = m_index_reg;
        m_last_next    = m_last_reg;
        m_status_next  = m_status_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_element_next = '0;
                    m_index_next   = '0;
                    m_last_next    = 1'b1;
                    m_status_next  = ST_OK;
                    m_valid_next   = 1'b1;
                    case (op)
                        OP_APPEND, OP_INSERT: begin
                            if (full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                cmd.op     = (op == OP_APPEND) ? CELL_APPEND : CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (empty) begin
                                m_status_next = ST_EMPTY;
                            end else if (pos_ext == '0 || pos_ext > CMP_W'(count_reg)) begin
                                m_status_next = ST_RANGE;
                            end else begin
                                cmd.op     = CELL_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                            if (empty) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                m_valid_next = 1'b0;
                                rd_idx_next  = '0;
                                state_next   = S_STREAM;
                            end
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (out_free) begin
                    cmd.op         = CELL_ROTATE;
                    m_valid_next   = 1'b1;
                    m_element_next = cell_data[0];
                    m_index_next   = EIDX_W'(rd_idx_reg);
                    m_last_next    = rd_last;
                    m_status_next  = ST_OK;
                    rd_idx_next    = rd_idx_reg + IDX_W'(1);
                    if (rd_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_element_reg <= m_element_next;
        m_index_reg   <= m_index_next;
        m_last_reg    <= m_last_next;
        m_status_reg  <= m_status_next;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (i == 0) begin : g_head
            assign left_d = s_value;
        end else begin : g_mid
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_body
            assign right_d = cell_data[i+1];
        end
        clst_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .idx        (IDX_W'(i)),
            .value      (s_value),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign m_valid         = m_valid_reg;
    assign m_element       = m_element_reg;
    assign m_element_index = m_index_reg;
    assign m_last          = m_last_reg;
    assign m_status        = m_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_stream_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STREAM) |-> (CNT_W'(rd_idx_reg) < count_reg))
        else $error("read-out index past count");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> $past(accept))
        else $error("count changed without an accepted item");

    a_mid_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status_reg == ST_OK && state_reg == S_STREAM))
        else $error("non-final result outside read-out");

    a_stream_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_STREAM) |-> $stable(count_reg))
        else $error("count changed during read-out");
`endif

endmodule
